FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the scheduler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define PPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included
`define PPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types and codes shared by the preemptive priority scheduler files.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_ZERO_BURST = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [7:0]  task_id;
    logic [7:0]  task_priority;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  done_task_id;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [31:0] finish_time;
  } out_item_t;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [15:0] remaining;
    logic [15:0] burst;
  } entry_t;

  // True when entry a beats entry b
  function automatic logic entry_beats(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = a.prio > b.prio;
    end else if (a.arrival != b.arrival) begin
      r = a.arrival < b.arrival;
    end else begin
      r = a.id < b.id;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/preemptive_priority_scheduler_core.sv
// An arrival result is registered in the cycle after acceptance; a tick passes
// through S_SCAN and S_UPDATE before its result reaches the result register (the scan reads
// one table entry per cycle from the entry memory).
// One arrival is taken per cycle while idle; no new input is taken until a tick has finished;
// in idle the input waits only while a result sits unaccepted in the output register.
// Reset clears the valid bits, the time counter and all control state.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Ready table with a sequential winner scan per tick, retire and reject reporting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preemptive_priority_scheduler_core #(
  parameter int MAX_TASKS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pps_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pps_pkg::out_item_t  out_data_o
);
  import pps_pkg::*;

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} state_e;

  state_e                state_q;
  logic [MAX_TASKS-1:0]  valid_q;
  logic [31:0]           time_q;
  logic [CW-1:0]         cnt_q;      // entries issued to the read port
  logic                  rd_pend_q;  // read data valid this cycle
  logic [AW-1:0]         rd_idx_q;
  logic                  win_found_q;
  logic [AW-1:0]         win_idx_q;
  entry_t                win_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  entry_t                wdata, rdata;

  // Lowest free slot
  logic                  free_found;
  logic [AW-1:0]         free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  // Output register is free when empty or being taken this cycle
  logic out_free;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  wire   accept     = in_valid_i && in_ready_o;

  assign raddr = cnt_q[AW-1:0];

  entry_t upd;
  always_comb begin
    upd           = win_q;
    upd.remaining = win_q.remaining - 16'd1;
  end

  logic        in_update;
  logic        retire;
  logic        out_set;
  logic [31:0] time_inc;
  assign in_update = (state_q == S_UPDATE);
  assign retire    = in_update && win_found_q && (upd.remaining == '0);
  assign time_inc  = time_q + 32'd1;
  assign out_set   = (accept && in_data_i.mode == MODE_ARRIVE &&
                      (in_data_i.burst_length == '0 || !free_found)) || retire;

  always_comb begin
    we    = 1'b0;
    waddr = free_idx;
    wdata = '0;
    if (accept && in_data_i.mode == MODE_ARRIVE && in_data_i.burst_length != '0
        && free_found) begin
      we              = 1'b1;
      wdata.id        = in_data_i.task_id;
      wdata.prio      = in_data_i.task_priority;
      wdata.arrival   = time_q;
      wdata.remaining = in_data_i.burst_length;
      wdata.burst     = in_data_i.burst_length;
    end else if (state_q == S_UPDATE && win_found_q) begin
      we    = 1'b1;
      waddr = win_idx_q;
      wdata = upd;
    end
  end

  pps_entry_mem #(.Depth(MAX_TASKS), .AW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  wire take = rd_pend_q && valid_q[rd_idx_q] &&
              (!win_found_q || entry_beats(rdata, win_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      time_q      <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      win_found_q <= 1'b0;
      win_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_data_i.mode == MODE_TICK) begin
              state_q     <= S_SCAN;
              cnt_q       <= '0;
              rd_pend_q   <= 1'b0;
              win_found_q <= 1'b0;
            end else if (in_data_i.burst_length == '0) begin
              out_q <= '{ST_ZERO_BURST, in_data_i.task_id, 32'd0, 32'd0, 32'd0};
            end else if (!free_found) begin
              out_q <= '{ST_FULL, in_data_i.task_id, 32'd0, 32'd0, 32'd0};
            end else begin
              valid_q[free_idx] <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // issue next read, fold returning data into the winner
          rd_pend_q <= (cnt_q != CW'(MAX_TASKS));
          rd_idx_q  <= cnt_q[AW-1:0];
          if (cnt_q != CW'(MAX_TASKS)) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (take) begin
            win_found_q <= 1'b1;
            win_idx_q   <= rd_idx_q;
            win_q       <= rdata;
          end
          if (cnt_q == CW'(MAX_TASKS) && !rd_pend_q) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          time_q  <= time_inc;
          state_q <= S_IDLE;
          if (retire) begin
            valid_q[win_idx_q] <= 1'b0;
            out_q.status       <= ST_DONE;
            out_q.done_task_id <= win_q.id;
            out_q.turnaround   <= time_inc - win_q.arrival;
            out_q.waiting      <= time_inc - win_q.arrival - {16'd0, win_q.burst};
            out_q.finish_time  <= time_inc;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PPS_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !in_ready_o, "busy")
  `PPS_ASSERT(a_tick_adv, clk_i, rst_ni, in_update |=> time_q == $past(time_inc), "no time step")
  `PPS_ASSERT(a_retire, clk_i, rst_ni, retire |=> !valid_q[$past(win_idx_q)], "retired kept")
endmodule

FILE: hw/rtl/pps_entry_mem.sv
// ----------------------------------------------------------------------------
// pps_entry_mem
// Task table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_entry_mem #(
  parameter int Depth = 16,
  parameter int AW    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  pps_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output pps_pkg::entry_t rdata_o
);
  import pps_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
